FILE: design/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and constants for the sorted integer set store: transaction
// payloads, command codes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int DATA_W           = 32;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic                     was_present;
        logic signed [DATA_W-1:0] element;
        logic [4:0]               member_count;
        logic                     status;
        logic                     last;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT_UP,
        ST_SHIFT_DOWN,
        ST_PUT,
        ST_RESULT,
        ST_LIST_RD,
        ST_LIST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic scan;
        logic start_up;
        logic start_down;
        logic shift_up;
        logic shift_down;
        logic put_value;
        logic drop_count;
        logic clear_count;
        logic set_reject;
        logic list_start;
        logic list_read;
        logic list_emit;
        logic result_emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       found;
        logic       full;
        logic       count_zero;
        logic       scan_done;
        logic       shift_busy;
        logic       list_last;
        logic       slot_free;
    } ctl_stat_t;

endpackage

FILE: design/sis_ram.sv
// ----------------------------------------------------------------------------
// sis_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read is not enabled.
// ----------------------------------------------------------------------------
module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/sis_ctrl.sv
// ----------------------------------------------------------------------------
// sis_ctrl
// Controller state machine: sequences scan, shift, update, list and result
// steps of the datapath for one transaction at a time.
// ----------------------------------------------------------------------------
module sis_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sis_pkg::ctl_stat_t  stat,
    output sis_pkg::ctl_cmd_t   cmd
);

    sis_pkg::state_t state_reg;
    sis_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sis_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sis_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sis_pkg::ST_SCAN;
                end
            end
            sis_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = sis_pkg::ST_DECIDE;
                end
            end
            sis_pkg::ST_DECIDE:
            begin
                unique case (stat.op)
                    sis_pkg::OP_INSERT:
                    begin
                        if (stat.found || stat.full)
                        begin
                            state_next = sis_pkg::ST_RESULT;
                        end
                        else
                        begin
                            state_next = sis_pkg::ST_SHIFT_UP;
                        end
                    end
                    sis_pkg::OP_REMOVE:
                    begin
                        if (stat.found)
                        begin
                            state_next = sis_pkg::ST_SHIFT_DOWN;
                        end
                        else
                        begin
                            state_next = sis_pkg::ST_RESULT;
                        end
                    end
                    sis_pkg::OP_LIST:
                    begin
                        if (stat.count_zero)
                        begin
                            state_next = sis_pkg::ST_RESULT;
                        end
                        else
                        begin
                            state_next = sis_pkg::ST_LIST_RD;
                        end
                    end
                    default:
                    begin
                        state_next = sis_pkg::ST_RESULT;
                    end
                endcase
            end
            sis_pkg::ST_SHIFT_UP:
            begin
                if (!stat.shift_busy)
                begin
                    state_next = sis_pkg::ST_PUT;
                end
            end
            sis_pkg::ST_SHIFT_DOWN:
            begin
                if (!stat.shift_busy)
                begin
                    state_next = sis_pkg::ST_RESULT;
                end
            end
            sis_pkg::ST_PUT:
            begin
                state_next = sis_pkg::ST_RESULT;
            end
            sis_pkg::ST_RESULT:
            begin
                if (stat.slot_free)
                begin
                    state_next = sis_pkg::ST_IDLE;
                end
            end
            sis_pkg::ST_LIST_RD:
            begin
                state_next = sis_pkg::ST_LIST_OUT;
            end
            sis_pkg::ST_LIST_OUT:
            begin
                if (stat.slot_free)
                begin
                    if (stat.list_last)
                    begin
                        state_next = sis_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = sis_pkg::ST_LIST_RD;
                    end
                end
            end
            default:
            begin
                state_next = sis_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            sis_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            sis_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            sis_pkg::ST_DECIDE:
            begin
                unique case (stat.op)
                    sis_pkg::OP_INSERT:
                    begin
                        cmd.set_reject = !stat.found && stat.full;
                        cmd.start_up   = !stat.found && !stat.full;
                    end
                    sis_pkg::OP_REMOVE:
                    begin
                        cmd.start_down = stat.found;
                    end
                    sis_pkg::OP_CLEAR:
                    begin
                        cmd.clear_count = 1'b1;
                    end
                    sis_pkg::OP_LIST:
                    begin
                        cmd.list_start = !stat.count_zero;
                    end
                    default:
                    begin
                    end
                endcase
            end
            sis_pkg::ST_SHIFT_UP:
            begin
                cmd.shift_up = 1'b1;
            end
            sis_pkg::ST_SHIFT_DOWN:
            begin
                cmd.shift_down = 1'b1;
                cmd.drop_count = !stat.shift_busy;
            end
            sis_pkg::ST_PUT:
            begin
                cmd.put_value = 1'b1;
            end
            sis_pkg::ST_RESULT:
            begin
                cmd.result_emit = stat.slot_free;
            end
            sis_pkg::ST_LIST_RD:
            begin
                cmd.list_read = 1'b1;
            end
            sis_pkg::ST_LIST_OUT:
            begin
                cmd.list_emit = stat.slot_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: design/sis_datapath.sv
// ----------------------------------------------------------------------------
// sis_datapath
// Member store, count, scan compare, shift pointers and the output
// register of the sorted integer set store.
// ----------------------------------------------------------------------------
module sis_datapath #(
    parameter int CAPACITY = sis_pkg::CAPACITY_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sis_pkg::in_t       in_item,
    input  sis_pkg::ctl_cmd_t  cmd,
    output sis_pkg::ctl_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output sis_pkg::out_t      out_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int DW = sis_pkg::DATA_W;

    logic [2:0]           op_reg,       op_next;
    logic signed [DW-1:0] value_reg,    value_next;
    logic [CW-1:0]        count_reg,    count_next;
    logic [CW-1:0]        pos_reg,      pos_next;
    logic                 found_reg,    found_next;
    logic                 reject_reg,   reject_next;
    logic [CW-1:0]        ptr_reg,      ptr_next;
    logic [CW-1:0]        lastrd_reg,   lastrd_next;
    logic                 more_reg,     more_next;
    logic                 pend_reg,     pend_next;
    logic                 out_valid_reg, out_valid_next;
    sis_pkg::out_t        out_item_reg, out_item_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    logic [CW-1:0] count_m1;
    logic [CW-1:0] up_addr;
    logic [CW-1:0] down_addr;
    logic [CW-1:0] pos_p1;
    logic [31:0]   count_wide;
    logic          count_zero;
    logic          full;
    logic          scan_ge;
    logic          scan_end;
    logic          slot_free;

    assign count_m1   = count_reg - 1'b1;
    assign up_addr    = lastrd_reg + 1'b1;
    assign down_addr  = lastrd_reg - 1'b1;
    assign pos_p1     = pos_reg + 1'b1;
    assign count_wide = 32'(count_reg);
    assign count_zero = (count_reg == '0);
    assign full       = (count_reg == CW'(CAPACITY));
    assign scan_ge    = pend_reg && ($signed(rd_data) >= value_reg);
    assign scan_end   = pend_reg && (lastrd_reg == count_m1);
    assign slot_free  = !out_valid_reg || out_ready;

    assign stat.op         = op_reg;
    assign stat.found      = found_reg;
    assign stat.full       = full;
    assign stat.count_zero = count_zero;
    assign stat.scan_done  = count_zero || scan_ge || scan_end;
    assign stat.shift_busy = more_reg || pend_reg;
    assign stat.list_last  = (lastrd_reg == count_m1);
    assign stat.slot_free  = slot_free;

    sis_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        op_next        = op_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        reject_next    = reject_reg;
        ptr_next       = ptr_reg;
        lastrd_next    = lastrd_reg;
        more_next      = more_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = pos_reg[AW-1:0];
        wr_data        = value_reg;

        if (cmd.load_item)
        begin
            op_next     = in_item.command;
            value_next  = in_item.value;
            ptr_next    = '0;
            pend_next   = 1'b0;
            reject_next = 1'b0;
        end

        if (cmd.scan)
        begin
            rd_en       = 1'b1;
            ptr_next    = ptr_reg + 1'b1;
            lastrd_next = ptr_reg;
            pend_next   = 1'b1;
            priority if (count_zero)
            begin
                found_next = 1'b0;
                pos_next   = '0;
            end
            else if (scan_ge)
            begin
                found_next = ($signed(rd_data) == value_reg);
                pos_next   = lastrd_reg;
            end
            else if (scan_end)
            begin
                found_next = 1'b0;
                pos_next   = count_reg;
            end
        end

        if (cmd.start_up)
        begin
            ptr_next  = count_m1;
            more_next = (count_reg != pos_reg);
            pend_next = 1'b0;
        end

        if (cmd.start_down)
        begin
            ptr_next  = pos_p1;
            more_next = (pos_p1 != count_reg);
            pend_next = 1'b0;
        end

        if (cmd.shift_up || cmd.shift_down)
        begin
            pend_next = more_reg;
            if (more_reg)
            begin
                rd_en       = 1'b1;
                lastrd_next = ptr_reg;
                if (cmd.shift_up)
                begin
                    more_next = (ptr_reg != pos_reg);
                    ptr_next  = ptr_reg - 1'b1;
                end
                else
                begin
                    more_next = (ptr_reg != count_m1);
                    ptr_next  = ptr_reg + 1'b1;
                end
            end
            if (pend_reg)
            begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                wr_addr = cmd.shift_up ? up_addr[AW-1:0] : down_addr[AW-1:0];
            end
        end

        if (cmd.put_value)
        begin
            wr_en      = 1'b1;
            count_next = count_reg + 1'b1;
        end

        if (cmd.drop_count)
        begin
            count_next = count_m1;
        end

        if (cmd.clear_count)
        begin
            count_next = '0;
        end

        if (cmd.set_reject)
        begin
            reject_next = 1'b1;
        end

        if (cmd.list_start)
        begin
            ptr_next = '0;
        end

        if (cmd.list_read)
        begin
            rd_en       = 1'b1;
            lastrd_next = ptr_reg;
            ptr_next    = ptr_reg + 1'b1;
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.result_emit)
        begin
            out_valid_next             = 1'b1;
            out_item_next.was_present  = found_reg;
            out_item_next.element      = '0;
            out_item_next.member_count = count_wide[4:0];
            out_item_next.status       = reject_reg ? sis_pkg::STATUS_FULL : sis_pkg::STATUS_OK;
            out_item_next.last         = 1'b1;
        end

        if (cmd.list_emit)
        begin
            out_valid_next             = 1'b1;
            out_item_next.was_present  = found_reg;
            out_item_next.element      = rd_data;
            out_item_next.member_count = count_wide[4:0];
            out_item_next.status       = sis_pkg::STATUS_OK;
            out_item_next.last         = (lastrd_reg == count_m1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            more_reg      <= more_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        value_reg    <= value_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        reject_reg   <= reject_next;
        ptr_reg      <= ptr_next;
        lastrd_reg   <= lastrd_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put_value |-> (count_reg < CW'(CAPACITY)))
        else $error("insert stored into a full set");

    a_put_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put_value |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("count did not advance after insert");

    a_drop_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_count |-> (found_reg && !count_zero))
        else $error("remove of an absent value");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.result_emit || cmd.list_emit) |-> slot_free)
        else $error("result loaded over a pending transaction");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("store read and written at the same entry");

endmodule

FILE: design/sorted_integer_set_store.sv
// ----------------------------------------------------------------------------
// sorted_integer_set_store
// Set of distinct signed 32-bit integers kept in ascending order, with
// insert, remove, lookup, clear and list commands.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one command and value per
// transaction; output channel out_valid/out_ready returns results. Every
// command gives one result with last set, except list, which gives one
// result per member in ascending order (last on the final one), or a single
// result with count zero for an empty set.
// Commands run one at a time. A command first scans the members through the
// store's single read port; insert and remove then move the entries above
// the position, one per cycle. List reads one member and returns it before
// reading the next. The next transaction can be accepted in the cycle after
// a command's final result is loaded.
// in_ready is high only while no command is in progress; a finished result
// sits in the output register, so the next transaction is taken while it
// waits. When the receiver stalls, results hold and the controller waits.
// Reset empties the set at once; stored entries need no clearing.
// ----------------------------------------------------------------------------
module sorted_integer_set_store #(
    parameter int CAPACITY = sis_pkg::CAPACITY_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sis_pkg::in_t  in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output sis_pkg::out_t out_item
);

    sis_pkg::ctl_cmd_t  cmd;
    sis_pkg::ctl_stat_t stat;

    sis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sis_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
